// ===== rtl/fmm_pkg.sv =====
// Shared widths, register indexes and status type of the filtered min/max/mean block.
`default_nettype none
package fmm_pkg;

	// Field widths
	localparam int YEAR_W     = 14;
	localparam int MONTH_W    = 4;
	localparam int VAL_W      = 15;
	localparam int CNT_OUT_W  = 13;

	// Configuration port
	localparam int CFG_W      = 14;
	localparam int CFG_IDX_W  = 1;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_YEAR  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_MONTH = 1'b1;

	// Month code that selects the whole year
	localparam logic [MONTH_W-1:0] MONTH_ANY = '0;

	// Default bound on records taken into one batch
	localparam int MAX_RECORDS_DEF = 4096;

	// Batch summary handed from the accumulator to the top level
	typedef struct packed {
		logic                    found;
		logic                    overflow;
		logic signed [VAL_W-1:0] min_val;
		logic signed [VAL_W-1:0] max_val;
	} acc_status_t;

endpackage
`default_nettype wire

// ===== rtl/fmm_accum.sv =====
// Running min, max, sum and count of records that pass the date filter.
`default_nettype none
module fmm_accum
	import fmm_pkg::*;
#(
	parameter int MAX_RECORDS = MAX_RECORDS_DEF,
	parameter int CNT_W       = $clog2(MAX_RECORDS + 1),
	parameter int SUM_W       = VAL_W + CNT_W
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic [YEAR_W-1:0]       target_year,
	input  wire logic [MONTH_W-1:0]      target_month,
	input  wire logic                    take,
	input  wire logic [YEAR_W-1:0]       record_year,
	input  wire logic [MONTH_W-1:0]      record_month,
	input  wire logic signed [VAL_W-1:0] reading,
	input  wire logic                    last,
	output acc_status_t                  fin_status,
	output logic signed [SUM_W-1:0]      fin_sum,
	output logic [CNT_W-1:0]             fin_count
);

	logic signed [VAL_W-1:0] min_q, max_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0]        count_q;
	logic                    seen_q, dropped_q;

	logic                    match, room;
	logic signed [VAL_W-1:0] min_nx, max_nx;
	logic signed [SUM_W-1:0] sum_nx;
	logic [CNT_W-1:0]        count_nx;
	logic                    seen_nx, dropped_nx;

	// Filter on year and month
	assign match = (record_year == target_year) &&
		((target_month == MONTH_ANY) || (record_month == target_month));
	assign room = (count_q < CNT_W'(MAX_RECORDS));

	// Fold the record into the running values
	always_comb begin
		min_nx     = min_q;
		max_nx     = max_q;
		sum_nx     = sum_q;
		count_nx   = count_q;
		seen_nx    = seen_q;
		dropped_nx = dropped_q;
		if (match) begin
			if (room) begin
				if (!seen_q || (reading < min_q)) begin
					min_nx = reading;
				end
				if (!seen_q || (reading > max_q)) begin
					max_nx = reading;
				end
				sum_nx   = sum_q + {{(SUM_W-VAL_W){reading[VAL_W-1]}}, reading};
				count_nx = count_q + 1'b1;
				seen_nx  = 1'b1;
			end else begin
				dropped_nx = 1'b1;
			end
		end
	end

	// Totals including the current record
	assign fin_status.found    = seen_nx;
	assign fin_status.overflow = dropped_nx;
	assign fin_status.min_val  = min_nx;
	assign fin_status.max_val  = max_nx;
	assign fin_sum             = sum_nx;
	assign fin_count           = count_nx;

	// Advance on each word; clear after the last one of a batch
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q     <= '0;
			max_q     <= '0;
			sum_q     <= '0;
			count_q   <= '0;
			seen_q    <= 1'b0;
			dropped_q <= 1'b0;
		end else if (take) begin
			if (last) begin
				min_q     <= '0;
				max_q     <= '0;
				sum_q     <= '0;
				count_q   <= '0;
				seen_q    <= 1'b0;
				dropped_q <= 1'b0;
			end else begin
				min_q     <= min_nx;
				max_q     <= max_nx;
				sum_q     <= sum_nx;
				count_q   <= count_nx;
				seen_q    <= seen_nx;
				dropped_q <= dropped_nx;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/fmm_div.sv =====
// Iterative restoring divider: one quotient bit per cycle, sign fixed at the end.
`default_nettype none
module fmm_div
	import fmm_pkg::*;
#(
	parameter int MAX_RECORDS = MAX_RECORDS_DEF,
	parameter int CNT_W       = $clog2(MAX_RECORDS + 1),
	parameter int SUM_W       = VAL_W + CNT_W
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic signed [SUM_W-1:0] dividend,
	input  wire logic [CNT_W-1:0]        divisor,
	output logic                         busy,
	output logic signed [SUM_W-1:0]      quotient
);

	localparam int STEP_W = $clog2(SUM_W + 1);

	logic [SUM_W-1:0]  dvd_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  dsr_q;
	logic              neg_q;
	logic [STEP_W-1:0] step_q;
	logic              busy_q;

	logic [CNT_W:0]    rem_sh;
	logic [CNT_W:0]    rem_sub;
	logic              q_bit;
	logic [SUM_W-1:0]  mag;

	// Magnitude of the dividend
	assign mag = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;

	// Shift in the next dividend bit and try the subtract
	assign rem_sh  = {rem_q, dvd_q[SUM_W-1]};
	assign rem_sub = rem_sh - {1'b0, dsr_q};
	assign q_bit   = (rem_sh >= {1'b0, dsr_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STEP_W'(SUM_W);
		end else if (busy_q) begin
			step_q <= step_q - 1'b1;
			if (step_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Datapath holds the partial remainder and the quotient bits shifted in
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= mag;
			rem_q <= '0;
			dsr_q <= divisor;
			neg_q <= dividend[SUM_W-1];
		end else if (busy_q) begin
			dvd_q <= {dvd_q[SUM_W-2:0], q_bit};
			rem_q <= q_bit ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
		end
	end

	assign busy     = busy_q;
	assign quotient = neg_q ? -$signed(dvd_q) : $signed(dvd_q);

endmodule
`default_nettype wire

// ===== rtl/filtered_min_max_mean_top.sv =====
// Top level of the filtered min/max/mean aggregator: config, sequencer and result register.
//
//  channel | handshake             | word
//  --------+-----------------------+------------------------------------------------
//  config  | cfg_we                | cfg_index, cfg_data
//  input   | in_valid / in_ready   | record_year, record_month, reading, last
//  output  | out_valid / out_ready | found, mean_value, min_value, max_value,
//          |                       | match_count, overflow
//
// A word without last is folded into the running values when taken. A word with last starts the divider,
// which works one quotient bit a cycle over SUM_W = 15 + clog2(MAX_RECORDS+1) bits
// (28 by default), then the result goes to the output register; input is held off meanwhile.
// Words of the next batch are taken while a result waits on out_ready.
// Reset clears the targets, the running values and the output valid.
`default_nettype none
module filtered_min_max_mean_top
	import fmm_pkg::*;
#(
	parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [CFG_W-1:0]         cfg_data,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [YEAR_W-1:0]        record_year,
	input  wire logic [MONTH_W-1:0]       record_month,
	input  wire logic signed [VAL_W-1:0]  reading,
	input  wire logic                     last,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic                          found,
	output logic signed [VAL_W-1:0]       mean_value,
	output logic signed [VAL_W-1:0]       min_value,
	output logic signed [VAL_W-1:0]       max_value,
	output logic [CNT_OUT_W-1:0]          match_count,
	output logic                          overflow
);

	localparam int CNT_W = $clog2(MAX_RECORDS + 1);
	localparam int SUM_W = VAL_W + CNT_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_HOLD = 2'd2;

	logic [1:0]              state_q;
	logic [YEAR_W-1:0]       target_year_q;
	logic [MONTH_W-1:0]      target_month_q;

	acc_status_t             fin_status;
	logic signed [SUM_W-1:0] fin_sum;
	logic [CNT_W-1:0]        fin_count;

	acc_status_t             stat_q;
	logic [CNT_W-1:0]        count_q;

	logic                    take, start, div_busy, load;
	logic signed [SUM_W-1:0] quotient;
	logic [CNT_W+CNT_OUT_W-1:0] count_ext;

	logic                    out_valid_q, found_q, overflow_q;
	logic signed [VAL_W-1:0] mean_q, min_q, max_q;
	logic [CNT_OUT_W-1:0]    match_count_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_year_q  <= '0;
			target_month_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TARGET_YEAR:  target_year_q  <= cfg_data[YEAR_W-1:0];
				REG_TARGET_MONTH: target_month_q <= cfg_data[MONTH_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_ready = (state_q == ST_IDLE);
	assign take     = in_valid && in_ready;
	assign start    = take && last;

	fmm_accum #(
		.MAX_RECORDS (MAX_RECORDS),
		.CNT_W       (CNT_W),
		.SUM_W       (SUM_W)
	) u_accum (
		.clk          (clk),
		.arst_n       (arst_n),
		.target_year  (target_year_q),
		.target_month (target_month_q),
		.take         (take),
		.record_year  (record_year),
		.record_month (record_month),
		.reading      (reading),
		.last         (last),
		.fin_status   (fin_status),
		.fin_sum      (fin_sum),
		.fin_count    (fin_count)
	);

	fmm_div #(
		.MAX_RECORDS (MAX_RECORDS),
		.CNT_W       (CNT_W),
		.SUM_W       (SUM_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.dividend (fin_sum),
		.divisor  (fin_count),
		.busy     (div_busy),
		.quotient (quotient)
	);

	// Hold the batch summary while the divider runs
	always_ff @(posedge clk) begin
		if (start) begin
			stat_q  <= fin_status;
			count_q <= fin_count;
		end
	end

	// Sequencer: idle, divide, wait for the output register
	assign load = (state_q == ST_HOLD) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (!div_busy) begin
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output register
	assign count_ext = {{CNT_OUT_W{1'b0}}, count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			found_q       <= stat_q.found;
			overflow_q    <= stat_q.overflow;
			mean_q        <= stat_q.found ? quotient[VAL_W-1:0] : '0;
			min_q         <= stat_q.min_val;
			max_q         <= stat_q.max_val;
			match_count_q <= count_ext[CNT_OUT_W-1:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign overflow    = overflow_q;
	assign mean_value  = mean_q;
	assign min_value   = min_q;
	assign max_value   = max_q;
	assign match_count = match_count_q;

endmodule
`default_nettype wire

// ===== rtl/fmm_checker.sv =====
// Port-level checks on the filtered min/max/mean top level, and their bind.
`default_nettype none
module fmm_checker
	import fmm_pkg::*;
(
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    in_valid,
	input wire logic                    in_ready,
	input wire logic                    last,
	input wire logic                    out_valid,
	input wire logic                    out_ready,
	input wire logic                    found,
	input wire logic signed [VAL_W-1:0] mean_value,
	input wire logic signed [VAL_W-1:0] min_value,
	input wire logic signed [VAL_W-1:0] max_value,
	input wire logic [CNT_OUT_W-1:0]    match_count
);

	// A stalled result holds its word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(mean_value) &&
		$stable(min_value) && $stable(max_value) && $stable(match_count))
		else $error("result word changed while stalled");

	// An empty batch reports zeros
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> mean_value == '0 && min_value == '0 &&
		max_value == '0 && match_count == '0)
		else $error("empty batch reported nonzero values");

	// Minimum never exceeds maximum
	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> min_value <= max_value)
		else $error("minimum above maximum");

	// Mean lies between minimum and maximum
	a_mean_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> mean_value >= min_value && mean_value <= max_value)
		else $error("mean outside min/max range");

	// Closing a batch holds off input while the divider runs
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && last |=> !in_ready)
		else $error("input taken right after last word");

endmodule

bind filtered_min_max_mean_top fmm_checker u_fmm_checker (.*);
`default_nettype wire

// ===== verif/fmm_batch_checker.sv =====
// Batch checker for the filtered min/max/mean block: predicts each batch summary and compares.
`default_nettype none
module fmm_batch_checker
	import fmm_pkg::*;
#(
	parameter int MAX_RECORDS = MAX_RECORDS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic [CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [CFG_W-1:0]        cfg_data,
	input  wire logic                    in_valid,
	input  wire logic                    in_ready,
	input  wire logic [YEAR_W-1:0]       record_year,
	input  wire logic [MONTH_W-1:0]      record_month,
	input  wire logic signed [VAL_W-1:0] reading,
	input  wire logic                    last,
	input  wire logic                    out_valid,
	input  wire logic                    out_ready,
	input  wire logic                    found,
	input  wire logic signed [VAL_W-1:0] mean_value,
	input  wire logic signed [VAL_W-1:0] min_value,
	input  wire logic signed [VAL_W-1:0] max_value,
	input  wire logic [CNT_OUT_W-1:0]    match_count,
	input  wire logic                    overflow,
	output int                           fail_count,
	output int                           pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic                    found;
		logic signed [VAL_W-1:0] mean;
		logic signed [VAL_W-1:0] lo;
		logic signed [VAL_W-1:0] hi;
		logic [CNT_OUT_W-1:0]    count;
		logic                    dropped;
	} batch_summary_t;

	// Filter targets as last written
	logic [YEAR_W-1:0]       want_year;
	logic [MONTH_W-1:0]      want_month;

	// Running values of the open batch
	logic signed [VAL_W-1:0] lo_seen;
	logic signed [VAL_W-1:0] hi_seen;
	longint                  reading_sum;
	int unsigned             taken;
	bit                      any_taken;
	bit                      any_dropped;

	// Summaries of closed batches, oldest first
	batch_summary_t          summary_q[$];

	initial fail_count = 0;

	function automatic void clear_batch();
		lo_seen     = '0;
		hi_seen     = '0;
		reading_sum = 0;
		taken       = 0;
		any_taken   = 1'b0;
		any_dropped = 1'b0;
	endfunction

	// Fold one record into the open batch; on the last record close it into a summary
	function automatic bit fold_record(input logic [YEAR_W-1:0] y, input logic [MONTH_W-1:0] m,
			input logic signed [VAL_W-1:0] r, input logic l, output batch_summary_t s);
		longint avg;
		avg = 0;
		if (y == want_year && (want_month == MONTH_ANY || m == want_month)) begin
			if (taken < MAX_RECORDS) begin
				if (!any_taken || r < lo_seen)
					lo_seen = r;
				if (!any_taken || r > hi_seen)
					hi_seen = r;
				reading_sum += r;
				taken++;
				any_taken = 1'b1;
			end else begin
				any_dropped = 1'b1;
			end
		end
		if (!l)
			return 1'b0;
		// Signed division truncates toward zero
		if (any_taken)
			avg = reading_sum / longint'(taken);
		s.found   = any_taken;
		s.mean    = any_taken ? avg[VAL_W-1:0] : '0;
		s.lo      = any_taken ? lo_seen : '0;
		s.hi      = any_taken ? hi_seen : '0;
		s.count   = taken[CNT_OUT_W-1:0];
		s.dropped = any_dropped;
		clear_batch();
		return 1'b1;
	endfunction

	task automatic compare_field(input string name, input longint want, input longint got);
		if (want != got) begin
			if (fail_count < 10)
				$display("%0t: %s expected %0d got %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		batch_summary_t want_s;
		batch_summary_t new_s;
		if (!arst_n) begin
			want_year  = '0;
			want_month = '0;
			clear_batch();
			summary_q.delete();
			pending <= 0;
		end else begin
			// Check a result word against the oldest summary
			if (out_valid && out_ready) begin
				if (summary_q.size() == 0) begin
					if (fail_count < 10)
						$display("%0t: result word with no batch closed", $time);
					fail_count++;
				end else begin
					want_s = summary_q.pop_front();
					compare_field("found", want_s.found, found);
					compare_field("mean_value", want_s.mean, mean_value);
					compare_field("min_value", want_s.lo, min_value);
					compare_field("max_value", want_s.hi, max_value);
					compare_field("match_count", want_s.count, match_count);
					compare_field("overflow", want_s.dropped, overflow);
				end
			end
			// Track register writes
			if (cfg_we) begin
				if (cfg_index == REG_TARGET_YEAR)
					want_year = cfg_data[YEAR_W-1:0];
				else if (cfg_index == REG_TARGET_MONTH)
					want_month = cfg_data[MONTH_W-1:0];
			end
			// Predict from each accepted record word
			if (in_valid && in_ready) begin
				if (fold_record(record_year, record_month, reading, last, new_s))
					summary_q.push_back(new_s);
			end
			pending <= summary_q.size();
		end
	end

endmodule
`default_nettype wire

// ===== verif/tb_filtered_min_max_mean_top.sv =====
// Testbench top for the filtered min/max/mean block: clock, reset, stimulus, receiver and verdict.
`default_nettype none
module tb_filtered_min_max_mean_top;
	import fmm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          HOLD_CYCLES  = 400;
	localparam int          SETTLE       = 4;
	localparam int          END_WAIT     = 40;
	localparam int          PHASE_WORDS  = 125;
	localparam int          BIG_BATCH    = 40;
	localparam int unsigned CYCLE_LIMIT  = 1000000;

	logic                    clk;
	logic                    arst_n;
	logic                    cfg_we;
	logic [CFG_IDX_W-1:0]    cfg_index;
	logic [CFG_W-1:0]        cfg_data;
	logic                    in_valid;
	logic                    in_ready;
	logic [YEAR_W-1:0]       record_year;
	logic [MONTH_W-1:0]      record_month;
	logic signed [VAL_W-1:0] reading;
	logic                    last;
	logic                    out_valid;
	logic                    out_ready;
	logic                    found;
	logic signed [VAL_W-1:0] mean_value;
	logic signed [VAL_W-1:0] min_value;
	logic signed [VAL_W-1:0] max_value;
	logic [CNT_OUT_W-1:0]    match_count;
	logic                    overflow;
	int                      fail_count;
	int                      pending;

	// Stimulus controls shared between the sender and the receiver
	bit                      tx_quiet;
	bit                      rx_quiet;
	bit                      hold_rx;
	logic [YEAR_W-1:0]       cur_year;
	logic [MONTH_W-1:0]      cur_month;
	int                      words_sent;
	int unsigned             cycle_count = 0;

	filtered_min_max_mean_top #(.MAX_RECORDS(MAX_RECORDS_DEF)) dut (.*);

	fmm_batch_checker #(.MAX_RECORDS(MAX_RECORDS_DEF)) checker_i (.*);

	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_filtered_min_max_mean_top NOT OK");
			$finish;
		end
	end

	// Mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 85)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic signed [VAL_W-1:0] pick_reading();
		int v;
		case ($urandom_range(0, 9))
			0: v = $urandom;
			1: v = ($urandom_range(0, 1) != 0) ? 10000 : -10000;
			default: v = $urandom_range(0, 20000) - 10000;
		endcase
		return VAL_W'(v);
	endfunction

	function automatic logic [MONTH_W-1:0] month_that_matches();
		if (cur_month != MONTH_ANY)
			return cur_month;
		if ($urandom_range(0, 9) == 0)
			return MONTH_W'($urandom_range(0, 15));
		return MONTH_W'($urandom_range(1, 12));
	endfunction

	// Offer one record word and hold it until taken
	task automatic send_record(input logic [YEAR_W-1:0] y, input logic [MONTH_W-1:0] m,
			input logic signed [VAL_W-1:0] r, input logic l);
		int gap;
		gap = tx_quiet ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		record_year  <= y;
		record_month <= m;
		reading      <= r;
		last         <= l;
		do @(posedge clk); while (!in_ready);
		words_sent++;
	endtask

	// Drop valid and wait out every pending result
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_targets(input logic [YEAR_W-1:0] y, input logic [MONTH_W-1:0] m);
		cfg_we    <= 1'b1;
		cfg_index <= REG_TARGET_YEAR;
		cfg_data  <= CFG_W'(y);
		@(posedge clk);
		cfg_index <= REG_TARGET_MONTH;
		cfg_data  <= CFG_W'(m);
		@(posedge clk);
		cfg_we    <= 1'b0;
		cur_year  = y;
		cur_month = m;
	endtask

	// One batch: hit_pct percent matching records, the rest off by year or month or fully random
	task automatic random_batch(input int len, input int hit_pct);
		logic [YEAR_W-1:0]  y;
		logic [MONTH_W-1:0] m;
		for (int i = 0; i < len; i++) begin
			y = cur_year;
			m = month_that_matches();
			if ($urandom_range(0, 99) >= hit_pct) begin
				case ($urandom_range(0, 2))
					0: y = cur_year ^ YEAR_W'(1 << $urandom_range(0, YEAR_W - 1));
					1: begin
						if (cur_month != MONTH_ANY)
							m = cur_month ^ MONTH_W'(1 << $urandom_range(0, MONTH_W - 1));
						else
							y = YEAR_W'($urandom);
					end
					default: begin
						y = YEAR_W'($urandom);
						m = MONTH_W'($urandom);
					end
				endcase
			end
			send_record(y, m, pick_reading(), i == len - 1);
		end
	endtask

	// Receiver: random ready pattern, one long hold-off on request
	initial begin
		int stall;
		out_ready = 1'b0;
		wait (arst_n);
		forever begin
			if (hold_rx) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rx = 1'b0;
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			stall = rx_quiet ? 0 : pick_gap();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// Sender and verdict
	initial begin
		int phase_end;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = REG_TARGET_YEAR;
		cfg_data     = '0;
		in_valid     = 1'b0;
		record_year  = '0;
		record_month = '0;
		reading      = '0;
		last         = 1'b0;
		tx_quiet     = 1'b0;
		rx_quiet     = 1'b0;
		hold_rx      = 1'b0;
		cur_year     = '0;
		cur_month    = MONTH_ANY;
		words_sent   = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset targets: year 0, whole year; single-record batch at the low extreme
		send_record(0, 1, -10000, 1'b1);
		// Range and field extremes, odd months, last record not matching
		send_record(0, 12, 10000, 1'b0);
		send_record(0, 0, 0, 1'b0);
		send_record(0, 15, -16384, 1'b0);
		send_record(0, 7, 16383, 1'b0);
		send_record(1, 5, 5, 1'b1);
		// Nothing matched
		send_record(9999, 6, 123, 1'b1);
		drain();

		// Target month beyond twelve, negative mean truncated toward zero
		set_targets(3141, 13);
		send_record(3141, 13, -1, 1'b0);
		send_record(3141, 3, 50, 1'b0);
		send_record(3141, 13, -2, 1'b1);
		drain();

		set_targets(9999, 12);
		send_record(9999, 12, 1, 1'b0);
		send_record(9999, 12, 2, 1'b0);
		send_record(9998, 12, 7, 1'b0);
		send_record(9999, 11, 9, 1'b1);
		drain();

		set_targets(16383, 15);
		send_record(16383, 15, 16383, 1'b0);
		send_record(16383, 15, -16384, 1'b0);
		send_record(16383, 14, 3, 1'b1);
		drain();

		// Random phases, each under its own targets
		for (int ph = 0; ph < 10; ph++) begin
			case (ph)
				0: set_targets(3141, MONTH_ANY);
				1: set_targets(9999, 12);
				2: set_targets(0, 1);
				3: set_targets(16383, MONTH_ANY);
				4: set_targets(YEAR_W'($urandom), MONTH_W'($urandom_range(13, 15)));
				default: set_targets(YEAR_W'($urandom), MONTH_W'($urandom_range(0, 12)));
			endcase
			tx_quiet = (ph == 5);
			rx_quiet = (ph == 5);
			if (ph == 3)
				hold_rx = 1'b1;
			phase_end = words_sent + PHASE_WORDS;
			while (words_sent < phase_end) begin
				random_batch(($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
				                                         : $urandom_range(1, 16),
				             ($urandom_range(0, 7) == 0) ? 0 : 75);
			end
			drain();
		end

		// One long back-to-back batch of matching records, then a short random one
		set_targets(5000, MONTH_ANY);
		tx_quiet = 1'b1;
		for (int i = 0; i < BIG_BATCH; i++)
			send_record(5000, month_that_matches(), pick_reading(), i == BIG_BATCH - 1);
		tx_quiet = 1'b0;
		random_batch(5, 75);
		drain();

		repeat (END_WAIT) @(posedge clk);
		if (fail_count == 0)
			$display("tb_filtered_min_max_mean_top OK");
		else
			$display("tb_filtered_min_max_mean_top NOT OK");
		$finish;
	end

endmodule
`default_nettype wire
